/* sv/sm83_pkg.sv */
`default_nettype none

package sm83_pkg;

	typedef enum logic [4:0] {
		MODE_ADD      = 5'd0,
		MODE_ADC      = 5'd1,
		MODE_SUB      = 5'd2,
		MODE_SBC      = 5'd3,
		MODE_AND      = 5'd4,
		MODE_XOR      = 5'd5,
		MODE_OR       = 5'd6,
		MODE_CP       = 5'd7,
		MODE_INC8     = 5'd8,
		MODE_DEC8     = 5'd9,
		MODE_RLC      = 5'd10,
		MODE_RRC      = 5'd11,
		MODE_RL       = 5'd12,
		MODE_RR       = 5'd13,
		MODE_SLA      = 5'd14,
		MODE_SRA      = 5'd15,
		MODE_SWAP     = 5'd16,
		MODE_SRL      = 5'd17,
		MODE_BIT      = 5'd18,
		MODE_RES      = 5'd19,
		MODE_SET      = 5'd20,
		MODE_ADD16    = 5'd21,
		MODE_ADD_SP_E = 5'd22,
		MODE_RLCA     = 5'd23,
		MODE_RRCA     = 5'd24,
		MODE_RLA      = 5'd25,
		MODE_RRA      = 5'd26,
		MODE_INC16    = 5'd27,
		MODE_DEC16    = 5'd28
	} mode_t;

	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [15:0] result;
		logic [3:0]  flags;
		logic        writes;
	} alu_res_t;

endpackage

`default_nettype wire

/* sv/sm83_alu.sv */
`default_nettype none

module sm83_alu (
	input  wire logic [4:0]         mode,
	input  wire logic [15:0]        operand_a,
	input  wire logic [15:0]        operand_b,
	input  wire logic [2:0]         bit_index,
	input  wire logic [3:0]         flags_in,
	output sm83_pkg::alu_res_t      res
);
	import sm83_pkg::*;

	always_comb begin
		logic [7:0]  a;
		logic [7:0]  b;
		logic        cin;
		logic        c_eff;
		logic [8:0]  sum9;
		logic [4:0]  sum5;
		logic [8:0]  dif9;
		logic [4:0]  dif5;
		logic [7:0]  r8;
		logic [7:0]  mask;
		logic [16:0] sum17;
		logic [12:0] sum13;
		logic [15:0] sext_b;

		a      = operand_a[7:0];
		b      = operand_b[7:0];
		cin    = flags_in[FLAG_C];
		c_eff  = (mode == MODE_ADC || mode == MODE_SBC) ? cin : 1'b0;
		sum9   = {1'b0, a} + {1'b0, b} + {8'b0, c_eff};
		sum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c_eff};
		dif9   = {1'b0, a} - {1'b0, b} - {8'b0, c_eff};
		dif5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, c_eff};
		mask   = 8'b1 << bit_index;
		sum17  = {1'b0, operand_a} + {1'b0, operand_b};
		sum13  = {1'b0, operand_a[11:0]} + {1'b0, operand_b[11:0]};
		sext_b = {{8{b[7]}}, b};
		r8     = 8'h00;

		res.result = operand_a;
		res.flags  = flags_in;
		res.writes = 1'b1;

		unique case (mode)
			MODE_ADD, MODE_ADC: begin
				r8 = sum9[7:0];
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, sum5[4], sum9[8]};
			end
			MODE_SUB, MODE_SBC, MODE_CP: begin
				r8 = dif9[7:0];
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b1, dif5[4], dif9[8]};
				res.writes = (mode != MODE_CP);
			end
			MODE_AND: begin
				r8 = a & b;
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			MODE_XOR: begin
				r8 = a ^ b;
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 3'b000};
			end
			MODE_OR: begin
				r8 = a | b;
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 3'b000};
			end
			MODE_INC8: begin
				r8 = a + 8'd1;
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
			end
			MODE_DEC8: begin
				r8 = a - 8'd1;
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
			end
			MODE_RLC, MODE_RLCA: begin
				r8 = {a[6:0], a[7]};
				res.result = {8'h00, r8};
				res.flags = {(mode == MODE_RLC) && (r8 == 8'h00), 2'b00, a[7]};
			end
			MODE_RRC, MODE_RRCA: begin
				r8 = {a[0], a[7:1]};
				res.result = {8'h00, r8};
				res.flags = {(mode == MODE_RRC) && (r8 == 8'h00), 2'b00, a[0]};
			end
			MODE_RL, MODE_RLA: begin
				r8 = {a[6:0], cin};
				res.result = {8'h00, r8};
				res.flags = {(mode == MODE_RL) && (r8 == 8'h00), 2'b00, a[7]};
			end
			MODE_RR, MODE_RRA: begin
				r8 = {cin, a[7:1]};
				res.result = {8'h00, r8};
				res.flags = {(mode == MODE_RR) && (r8 == 8'h00), 2'b00, a[0]};
			end
			MODE_SLA: begin
				r8 = {a[6:0], 1'b0};
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 2'b00, a[7]};
			end
			MODE_SRA: begin
				r8 = {a[7], a[7:1]};
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 2'b00, a[0]};
			end
			MODE_SWAP: begin
				r8 = {a[3:0], a[7:4]};
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 3'b000};
			end
			MODE_SRL: begin
				r8 = {1'b0, a[7:1]};
				res.result = {8'h00, r8};
				res.flags = {r8 == 8'h00, 2'b00, a[0]};
			end
			MODE_BIT: begin
				res.result = {8'h00, a};
				res.flags = {(a & mask) == 8'h00, 1'b0, 1'b1, cin};
				res.writes = 1'b0;
			end
			MODE_RES: begin
				res.result = {8'h00, a & ~mask};
			end
			MODE_SET: begin
				res.result = {8'h00, a | mask};
			end
			MODE_ADD16: begin
				res.result = sum17[15:0];
				res.flags = {flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]};
			end
			MODE_ADD_SP_E: begin
				res.result = operand_a + sext_b;
				res.flags = {2'b00,
					({1'b0, operand_a[3:0]} + {1'b0, b[3:0]}) > 5'h0F,
					({1'b0, operand_a[7:0]} + {1'b0, b}) > 9'h0FF};
			end
			MODE_INC16: begin
				res.result = operand_a + 16'd1;
			end
			MODE_DEC16: begin
				res.result = operand_a - 16'd1;
			end
			default: begin
				res.result = operand_a;
				res.flags = flags_in;
				res.writes = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/sm83_alu_with_flags.sv */
// SM83-style arithmetic-logic unit with flag generation.
// The request channel carries mode, operand_a, operand_b, bit_index and
// flags_in and is accepted on a rising edge where in_valid is high and
// in_stall is low. The result channel carries result, flags_out and
// writes_result and is taken on an edge where out_valid is high and
// out_stall is low. Each request yields exactly one result, in order.
// A request is captured in an input register, passes through the ALU and
// lands in the result register once that register is free or its result
// is being taken; out_valid then rises. One request is accepted per cycle
// while the receiver keeps taking results.
// When the receiver stalls, the result register holds its contents and the
// input register still takes one more request; in_stall rises only when
// both registers are full and the output is stalled.
// The asynchronous reset empties both registers; no result is pending
// afterwards and the block is ready at once.
`default_nettype none

module sm83_alu_with_flags (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  mode,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	input  wire logic [2:0]  bit_index,
	input  wire logic [3:0]  flags_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      result,
	output logic [3:0]       flags_out,
	output logic             writes_result
);
	import sm83_pkg::*;

	logic        valid_s1;
	logic [4:0]  mode_s1;
	logic [15:0] operand_a_s1;
	logic [15:0] operand_b_s1;
	logic [2:0]  bit_index_s1;
	logic [3:0]  flags_in_s1;
	logic        valid_s2;
	alu_res_t    res_s2;
	alu_res_t    alu_res;
	logic        load_s2;
	logic        load_s1;

	sm83_alu u_alu (
		.mode      (mode_s1),
		.operand_a (operand_a_s1),
		.operand_b (operand_b_s1),
		.bit_index (bit_index_s1),
		.flags_in  (flags_in_s1),
		.res       (alu_res)
	);

	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1      <= mode;
			operand_a_s1 <= operand_a;
			operand_b_s1 <= operand_b;
			bit_index_s1 <= bit_index;
			flags_in_s1  <= flags_in;
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= alu_res;
		end
	end

	assign out_valid     = valid_s2;
	assign result        = res_s2.result;
	assign flags_out     = res_s2.flags;
	assign writes_result = res_s2.writes;

`ifndef NO_ASSERTIONS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled while a register stage was free");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request did not reach the input register");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_stall) |=> valid_s2)
		else $error("input register content did not move to the result register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result register changed");
`endif

endmodule

`default_nettype wire
